// File: hdl/mhkt_pkg.sv
// Shared types and constants of the masked hash key table.
// No dependencies; used by mhkt_ctrl, mhkt_dp and the top level.
package mhkt_pkg;

   // Field widths fixed by the payload format.
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;
   localparam int ORDER_W  = 4;

   // Defaults for the top-level parameters.
   localparam int ORDER_MAX_DEFAULT = 10;
   localparam int WAYS_DEFAULT      = 4;

   // Order register value after reset.
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

   // Action codes.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]          action;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [HANDLE_W-1:0] found_handle;
   } rsp_type;

   // One way of a bucket row as held in the RAM.
   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic issue;   // read the bucket row of the incoming request
      logic finish;  // resolve the lookup, write back, load the result
      logic clear;   // write an empty row at the sweep address
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;  // result register can take a new result this cycle
   } stat_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP
   } state_type;

endpackage

// File: hdl/mhkt_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module mhkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mhkt_ctrl.sv
// Controller of the masked hash key table: clearing sweep, lookup sequencing.
// Depends on mhkt_pkg.
module mhkt_ctrl #(
   parameter int ORDER_MAX = mhkt_pkg::ORDER_MAX_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    csr_fire,
   input  mhkt_pkg::stat_type      stat,
   output mhkt_pkg::cmd_type       cmd,
   output logic [ORDER_MAX-1:0]    clear_addr
);

   mhkt_pkg::state_type state_ff, state_in;
   logic [ORDER_MAX-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mhkt_pkg::S_CLEAR;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         mhkt_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            count_in  = count_ff + 1'b1;
            if (count_ff == '1) begin
               state_in = mhkt_pkg::S_IDLE;
            end
         end
         mhkt_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.issue = 1'b1;
               state_in  = mhkt_pkg::S_LOOKUP;
            end
         end
         mhkt_pkg::S_LOOKUP: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = mhkt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mhkt_pkg::S_CLEAR;
            count_in = '0;
         end
      endcase
      // an order write empties the table: restart the sweep
      if (csr_fire) begin
         state_in = mhkt_pkg::S_CLEAR;
         count_in = '0;
      end
   end

   assign clear_addr = count_ff;

endmodule

// File: hdl/mhkt_dp.sv
// Datapath of the masked hash key table: order register, bucket RAM,
// way compare, row update and result register.
// Depends on mhkt_pkg and mhkt_ram.
module mhkt_dp #(
   parameter int ORDER_MAX = mhkt_pkg::ORDER_MAX_DEFAULT,
   parameter int WAYS      = mhkt_pkg::WAYS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mhkt_pkg::req_type                 req_payload,
   input  logic                              csr_fire,
   input  logic [mhkt_pkg::ORDER_W-1:0]      csr_data,
   input  mhkt_pkg::cmd_type                 cmd,
   input  logic [ORDER_MAX-1:0]              clear_addr,
   output mhkt_pkg::stat_type                stat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mhkt_pkg::rsp_type                 rsp_payload
);

   localparam int ROW_AW = ORDER_MAX;
   localparam int ROWS   = 1 << ORDER_MAX;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W  = WAYS * $bits(mhkt_pkg::entry_type);
   localparam logic [4:0] ORDER_MAX_V = 5'(ORDER_MAX);

   logic [mhkt_pkg::ORDER_W-1:0] order_ff;
   mhkt_pkg::req_type            item_ff;
   mhkt_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff;

   logic [4:0]        eff_order;
   logic [ROW_AW-1:0] bucket_mask;
   logic [ROW_AW-1:0] rd_bucket;
   logic [ROW_AW-1:0] item_bucket;

   mhkt_pkg::entry_type [WAYS-1:0] rd_row;
   mhkt_pkg::entry_type [WAYS-1:0] new_row;
   logic [ROW_W-1:0]  rd_data;
   logic              wr_en;
   logic [ROW_AW-1:0] wr_addr;
   logic [ROW_W-1:0]  wr_data;

   logic             hit, hit_both, free_any;
   logic [WAY_W-1:0] hit_way, hit_both_way, free_way;
   logic             row_we;

   // effective order, clamped to the table size
   always_comb begin
      eff_order = ({1'b0, order_ff} > ORDER_MAX_V) ? ORDER_MAX_V : {1'b0, order_ff};
   end

   assign bucket_mask = ~({ROW_AW{1'b1}} << eff_order);
   assign rd_bucket   = req_payload.key[ROW_AW-1:0] & bucket_mask;
   assign item_bucket = item_ff.key[ROW_AW-1:0] & bucket_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= mhkt_pkg::ORDER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            order_ff <= csr_data;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         item_ff <= req_payload;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   mhkt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (rd_bucket),
      .rd_data (rd_data)
   );

   assign rd_row = rd_data;

   // parallel compare over the ways; lowest way wins
   always_comb begin
      hit          = 1'b0;
      hit_both     = 1'b0;
      free_any     = 1'b0;
      hit_way      = '0;
      hit_both_way = '0;
      free_way     = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_row[w].valid) begin
            if (rd_row[w].key == item_ff.key) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
               if (rd_row[w].handle == item_ff.handle) begin
                  hit_both     = 1'b1;
                  hit_both_way = WAY_W'(w);
               end
            end
         end else begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_row             = rd_row;
      row_we              = 1'b0;
      rsp_in.status       = mhkt_pkg::STATUS_MISS;
      rsp_in.found_handle = '0;
      case (item_ff.action)
         mhkt_pkg::ACT_INSERT: begin
            if (hit) begin
               rsp_in.status = mhkt_pkg::STATUS_DUP;
            end else if (!free_any) begin
               rsp_in.status = mhkt_pkg::STATUS_FULL;
            end else begin
               new_row[free_way].valid  = 1'b1;
               new_row[free_way].key    = item_ff.key;
               new_row[free_way].handle = item_ff.handle;
               row_we                   = 1'b1;
               rsp_in.status            = mhkt_pkg::STATUS_OK;
            end
         end
         mhkt_pkg::ACT_FIND: begin
            if (hit) begin
               rsp_in.status       = mhkt_pkg::STATUS_OK;
               rsp_in.found_handle = rd_row[hit_way].handle;
            end
         end
         mhkt_pkg::ACT_REMOVE: begin
            if (hit_both) begin
               new_row[hit_both_way].valid = 1'b0;
               row_we                      = 1'b1;
               rsp_in.status               = mhkt_pkg::STATUS_OK;
            end
         end
         default: begin
            rsp_in.status = mhkt_pkg::STATUS_MISS;
         end
      endcase
   end

   // sweep writes an empty row; lookup writes back the updated row
   always_comb begin
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr;
         wr_data = '0;
      end else begin
         wr_en   = cmd.finish && row_we;
         wr_addr = item_bucket;
         wr_data = new_row;
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

endmodule

// File: hdl/masked_hash_key_table.sv
// Top level of the masked hash key table.
// Depends on mhkt_pkg, mhkt_ctrl, mhkt_dp (and through it mhkt_ram).
//
// A table of unique keys, each paired with a caller handle. A key's bucket
// is its low order_in_use bits (values above ORDER_MAX act as ORDER_MAX);
// each bucket holds WAYS entries, kept as one row of a RAM of
// 2**ORDER_MAX rows. Insert puts the pair in the lowest free way, answering
// duplicate or bucket full when it cannot; find returns the stored handle;
// remove clears the entry whose key and handle both match. Each request
// first reads the bucket row, then compares all ways in parallel, writes the
// row back and loads the result register. The next request is taken while
// a result still waits in that register; a request only waits further if
// the result register is still occupied when its lookup completes. After
// reset, and after every write of order_in_use, the table is emptied by a
// sweep over all 2**ORDER_MAX rows (1024 by default), one row a cycle,
// during which req_stall is high. csr writes are taken at any time
// (csr_ready is tied high) but belong to idle periods; a write during a
// sweep restarts it.
module masked_hash_key_table #(
   parameter int ORDER_MAX = mhkt_pkg::ORDER_MAX_DEFAULT,
   parameter int WAYS      = mhkt_pkg::WAYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mhkt_pkg::req_type             req_payload,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mhkt_pkg::rsp_type             rsp_payload,
   // order_in_use register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mhkt_pkg::ORDER_W-1:0]  csr_data
);

   mhkt_pkg::cmd_type    cmd;
   mhkt_pkg::stat_type   stat;
   logic [ORDER_MAX-1:0] clear_addr;
   logic                 csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;  // register transfer

   // sequencing: sweep, idle, lookup
   mhkt_ctrl #(
      .ORDER_MAX (ORDER_MAX)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .csr_fire   (csr_fire),
      .stat       (stat),
      .cmd        (cmd),
      .clear_addr (clear_addr)
   );

   // bucket rows, compare, write-back and result register
   mhkt_dp #(
      .ORDER_MAX (ORDER_MAX),
      .WAYS      (WAYS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_fire    (csr_fire),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .clear_addr  (clear_addr),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
